/* design/pwm_pkg.sv */
// Shared types and constants for the Prewitt edge magnitude core.
package pwm_pkg;

    localparam int PIX_W    = 8;
    localparam int MAG_W    = 11;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;
    localparam int WCFG_W   = 11;
    localparam int HGT_W    = 16;
    localparam int SUM_W    = 10;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 20;
    localparam int RAD_W    = 21;
    localparam int ROOT_STEPS = 11;
    localparam int STEP_W   = 4;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_OUT
    } pwm_state_t;

    typedef struct packed {
        logic accept;
        logic calc;
        logic square;
        logic sum;
        logic root_step;
        logic load_out;
    } pwm_cmd_t;

    typedef struct packed {
        logic emit;
        logic root_last;
        logic out_free;
    } pwm_status_t;

endpackage

/* design/prewitt_edge_magnitude_core.sv */
// Top level of the streaming 3x3 Prewitt edge magnitude core.
// Pixels arrive in raster order; each accepted transaction produces the gradient magnitude for
// the position width+1 transactions earlier (zero on frame borders), with frame_last on the
// frame's final result, which width+1 pad transactions after the last pixel flush out. An
// item yielding no result passes the idle and calc states; one yielding a result also passes
// the square, sum, root (11-step two-bits-per-step integer square root) and output states,
// waiting there while the output stalls. The two line stores are RAMs of MAX_WIDTH entries
// with no clearing pass. A width or height write restarts the frame; cfg_ready is always high.
module prewitt_edge_magnitude_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pwm_pkg::PIX_W-1:0]     pixel,
    input  logic                          pad,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pwm_pkg::MAG_W-1:0]     magnitude,
    output logic                          frame_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pwm_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pwm_pkg::CFG_W-1:0]     cfg_data
);
    import pwm_pkg::*;

    pwm_cmd_t    cmd;
    pwm_status_t status;

    assign cfg_ready = 1'b1;

    pwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pwm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .pixel      (pixel),
        .pad        (pad),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .magnitude  (magnitude),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

endmodule

/* design/pwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* design/pwm_ctrl.sv */
// Sequencing state machine for the Prewitt edge magnitude core.
module pwm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pwm_pkg::pwm_status_t status,
    output pwm_pkg::pwm_cmd_t    cmd
);
    import pwm_pkg::*;

    pwm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = status.emit ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/pwm_datapath.sv */
// Line stores, window, gradient arithmetic, root unit and output register.
module pwm_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pwm_pkg::pwm_cmd_t             cmd,
    output pwm_pkg::pwm_status_t          status,
    input  logic [pwm_pkg::PIX_W-1:0]     pixel,
    input  logic                          pad,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pwm_pkg::MAG_W-1:0]     magnitude,
    output logic                          frame_last,
    input  logic                          cfg_valid,
    input  logic [pwm_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pwm_pkg::CFG_W-1:0]     cfg_data
);
    import pwm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > WCFG_W) ? AW + 1 : WCFG_W;
    localparam int RW = HGT_W + 1;

    logic [WW-1:0]    width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [WW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [PIX_W-1:0] win_reg [6];
    logic [PIX_W-1:0] px_reg;

    logic [PIX_W-1:0] up_data, lo_data;

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [RAD_W-1:0] rem_reg, root_reg, bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic             last_reg;
    logic             out_valid_reg;
    logic [MAG_W-1:0] mag_reg;
    logic             flast_reg;

    logic [WW-1:0]    w_clamp;
    logic [HGT_W-1:0] h_clamp;
    logic             emit;
    logic [RW-1:0]    pr;
    logic [WW-1:0]    pc;
    logic             last, interior;
    logic [SUM_W-1:0] top, bot, lft, rgt;
    logic signed [GRAD_W-1:0] gx, gy;
    logic [WW-1:0]    col_inc;
    logic [RAD_W-1:0] trial;
    logic             cfg_write;

    pwm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (cmd.calc),
        .waddr (col_reg[AW-1:0]),
        .wdata (lo_data),
        .re    (cmd.accept),
        .raddr (col_reg[AW-1:0]),
        .rdata (up_data)
    );

    pwm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .clk   (clk),
        .we    (cmd.calc),
        .waddr (col_reg[AW-1:0]),
        .wdata (px_reg),
        .re    (cmd.accept),
        .raddr (col_reg[AW-1:0]),
        .rdata (lo_data)
    );

    always_comb
    begin
        w_clamp = WW'(cfg_data[WCFG_W-1:0]);
        if (w_clamp < WW'(3))
        begin
            w_clamp = WW'(3);
        end
        else if (w_clamp > WW'(MAX_WIDTH))
        begin
            w_clamp = WW'(MAX_WIDTH);
        end
        h_clamp = cfg_data[HGT_W-1:0];
        if (h_clamp < HGT_W'(3))
        begin
            h_clamp = HGT_W'(3);
        end
    end

    assign cfg_write = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_comb
    begin
        emit = (row_reg >= RW'(2)) || (row_reg == RW'(1) && col_reg != '0);
        pr   = (col_reg != '0) ? row_reg - RW'(1) : row_reg - RW'(2);
        pc   = (col_reg != '0) ? col_reg - WW'(1) : width_reg - WW'(1);
        last = (pr == RW'(height_reg) - RW'(1)) && (pc == width_reg - WW'(1));
        interior = (pr != '0) && (pr < RW'(height_reg) - RW'(1))
                && (pc != '0) && (pc < width_reg - WW'(1));
        top = SUM_W'(win_reg[0]) + SUM_W'(win_reg[3]) + SUM_W'(up_data);
        bot = SUM_W'(win_reg[2]) + SUM_W'(win_reg[5]) + SUM_W'(px_reg);
        lft = SUM_W'(win_reg[0]) + SUM_W'(win_reg[1]) + SUM_W'(win_reg[2]);
        rgt = SUM_W'(up_data) + SUM_W'(lo_data) + SUM_W'(px_reg);
        gx  = $signed({1'b0, bot}) - $signed({1'b0, top});
        gy  = $signed({1'b0, rgt}) - $signed({1'b0, lft});
        col_inc = col_reg + WW'(1);
        trial   = root_reg + bit_reg;
    end

    assign status.emit      = emit;
    assign status.root_last = (step_reg == STEP_W'(ROOT_STEPS - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
            height_reg <= HGT_W'(1024);
            col_reg    <= '0;
            row_reg    <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                width_reg <= w_clamp;
            end
            else
            begin
                height_reg <= h_clamp;
            end
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.calc)
        begin
            if (emit && last)
            begin
                col_reg <= '0;
                row_reg <= '0;
                for (int i = 0; i < 6; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= up_data;
                win_reg[4] <= lo_data;
                win_reg[5] <= px_reg;
                if (col_inc >= width_reg)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg <= pad ? '0 : pixel;
        end
        if (cmd.calc)
        begin
            gx_reg   <= interior ? gx : '0;
            gy_reg   <= interior ? gy : '0;
            last_reg <= last;
        end
        if (cmd.square)
        begin
            sqx_reg <= SQ_W'(gx_reg * gx_reg);
            sqy_reg <= SQ_W'(gy_reg * gy_reg);
        end
        if (cmd.sum)
        begin
            rem_reg  <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            root_reg <= '0;
            bit_reg  <= RAD_W'(1) << (RAD_W - 1);
            step_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.load_out)
        begin
            mag_reg   <= root_reg[MAG_W-1:0];
            flast_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign magnitude  = mag_reg;
    assign frame_last = flast_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an untaken result");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < width_reg)
        else $error("column count reached image width");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (mag_reg <= MAG_W'(1081)))
        else $error("magnitude above bound");

endmodule
